/* design/rtcw_pkg.sv */
// Package with the phase type and fixed constants of the three-wire clock master.
package rtcw_pkg;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_RAISE = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_WR    = 6'b001000,
    PH_RD    = 6'b010000,
    PH_END   = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    CFG_WRITE_LOW = 2'd0,
    CFG_READ_LOW  = 2'd1,
    CFG_HIGH      = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] CMD_READ  = 8'h61;
  localparam logic [7:0] CMD_WRITE = 8'h60;

  localparam logic [3:0] WRITE_LOW_RESET = 4'd3;
  localparam logic [3:0] READ_LOW_RESET  = 4'd5;
  localparam logic [3:0] HIGH_RESET      = 4'd1;

  localparam logic [3:0] MAX_BYTES = 4'd8;
  localparam logic [2:0] LAST_BIT  = 3'd7;

endpackage

/* design/rtc_three_wire_master_core.sv */
// Top level of the three-wire real-time clock master, one tick per input beat.
// A result beat appears in the cycle after its input beat is accepted.
// One input beat per cycle while the receiver takes the results; the sequencer state and the output
// register are updated together, so back-to-back beats are taken without gaps.
// Reset clears the sequencer to idle, the tick registers to their defaults and
// the output register to empty.
module rtc_three_wire_master_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic        write_mode_i,
  input  logic [2:0]  reg_index_i,
  input  logic [3:0]  byte_count_i,
  input  logic [63:0] write_payload_i,
  input  logic        sio_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        sck_o,
  output logic        sio_out_o,
  output logic        sio_drive_o,
  output logic        chip_select_o,
  output logic [63:0] read_payload_o,
  output logic        done_res_o,
  output logic        busy_res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i
);

  logic [3:0] wr_low_q, rd_low_q, high_q;

  rtcw_pkg::phase_e phase_q, phase_d;
  logic [3:0]  tick_q, tick_d;
  logic        clk_high_q, clk_high_d;
  logic [2:0]  bit_q, bit_d;
  logic [3:0]  left_q, left_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [63:0] sout_q, sout_d;
  logic [63:0] sin_q, sin_d;
  logic        is_write_q, is_write_d;

  logic        out_valid_q;
  logic        sck_q, sdo_q, drv_q, cs_q, done_q, busy_q;
  logic [63:0] rdp_q;

  logic        sck_c, sdo_c, drv_c, cs_c, done_c, busy_c;
  logic        accept;
  logic [3:0]  low_raw, low_lim, high_lim, cnt_clamp, left_dec;
  logic [4:0]  tick_nxt;
  logic        adv_high, adv_end;
  logic [3:0]  adv_tick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_low_q <= rtcw_pkg::WRITE_LOW_RESET;
      rd_low_q <= rtcw_pkg::READ_LOW_RESET;
      high_q   <= rtcw_pkg::HIGH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rtcw_pkg::CFG_WRITE_LOW: wr_low_q <= cfg_wdata_i;
        rtcw_pkg::CFG_READ_LOW:  rd_low_q <= cfg_wdata_i;
        rtcw_pkg::CFG_HIGH:      high_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Bit timing shared by the command, write and read phases.
  always_comb begin
    low_raw  = (phase_q == rtcw_pkg::PH_RD) ? rd_low_q : wr_low_q;
    low_lim  = (low_raw == 4'd0) ? 4'd1 : low_raw;
    high_lim = (high_q == 4'd0) ? 4'd1 : high_q;
    tick_nxt = {1'b0, tick_q} + 5'd1;
    adv_end  = 1'b0;
    adv_high = clk_high_q;
    adv_tick = tick_nxt[3:0];
    if (!clk_high_q) begin
      if (tick_nxt >= {1'b0, low_lim}) begin
        adv_tick = 4'd0;
        adv_high = 1'b1;
      end
    end else if (tick_nxt >= {1'b0, high_lim}) begin
      adv_tick = 4'd0;
      adv_high = 1'b0;
      adv_end  = 1'b1;
    end
    cnt_clamp = (byte_count_i > rtcw_pkg::MAX_BYTES) ? rtcw_pkg::MAX_BYTES : byte_count_i;
    left_dec  = (left_q != 4'd0) ? left_q - 4'd1 : left_q;
  end

  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    clk_high_d = clk_high_q;
    bit_d      = bit_q;
    left_d     = left_q;
    cmd_d      = cmd_q;
    sout_d     = sout_q;
    sin_d      = sin_q;
    is_write_d = is_write_q;
    sck_c      = 1'b1;
    sdo_c      = 1'b0;
    drv_c      = 1'b0;
    cs_c       = 1'b0;
    done_c     = 1'b0;
    busy_c     = 1'b0;
    unique case (phase_q) inside
      rtcw_pkg::PH_IDLE: begin
        if (start_req_i) begin
          is_write_d = write_mode_i;
          left_d     = cnt_clamp;
          cmd_d      = {4'd0, reg_index_i, 1'b0}
                       | (write_mode_i ? rtcw_pkg::CMD_WRITE : rtcw_pkg::CMD_READ);
          sout_d     = write_mode_i ? write_payload_i : 64'd1;
          sin_d      = 64'd0;
          tick_d     = 4'd0;
          bit_d      = 3'd0;
          clk_high_d = 1'b0;
          drv_c      = 1'b1;
          busy_c     = 1'b1;
          phase_d    = rtcw_pkg::PH_RAISE;
        end
      end
      rtcw_pkg::PH_RAISE: begin
        cs_c    = 1'b1;
        drv_c   = 1'b1;
        busy_c  = 1'b1;
        phase_d = rtcw_pkg::PH_CMD;
      end
      rtcw_pkg::PH_CMD: begin
        cs_c       = 1'b1;
        drv_c      = 1'b1;
        busy_c     = 1'b1;
        sck_c      = clk_high_q;
        sdo_c      = cmd_q[7];
        tick_d     = adv_tick;
        clk_high_d = adv_high;
        if (adv_end) begin
          cmd_d = {cmd_q[6:0], 1'b0};
          if (bit_q != rtcw_pkg::LAST_BIT) begin
            bit_d = bit_q + 3'd1;
          end else begin
            bit_d = 3'd0;
            if (left_q == 4'd0) begin
              phase_d = rtcw_pkg::PH_END;
            end else begin
              phase_d = is_write_q ? rtcw_pkg::PH_WR : rtcw_pkg::PH_RD;
            end
          end
        end
      end
      rtcw_pkg::PH_WR, rtcw_pkg::PH_RD: begin
        cs_c       = 1'b1;
        drv_c      = (phase_q == rtcw_pkg::PH_WR);
        busy_c     = 1'b1;
        sck_c      = clk_high_q;
        sdo_c      = (phase_q == rtcw_pkg::PH_WR) && sout_q[0];
        tick_d     = adv_tick;
        clk_high_d = adv_high;
        if (adv_end) begin
          if (phase_q == rtcw_pkg::PH_WR) begin
            sout_d = {1'b0, sout_q[63:1]};
          end else begin
            sin_d  = sio_in_i ? (sin_q | sout_q) : sin_q;
            sout_d = {sout_q[62:0], 1'b0};
          end
          if (bit_q != rtcw_pkg::LAST_BIT) begin
            bit_d = bit_q + 3'd1;
          end else begin
            bit_d  = 3'd0;
            left_d = left_dec;
            if (left_dec == 4'd0) begin
              phase_d = rtcw_pkg::PH_END;
            end
          end
        end
      end
      rtcw_pkg::PH_END: begin
        done_c  = 1'b1;
        phase_d = rtcw_pkg::PH_IDLE;
      end
      default: phase_d = rtcw_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rtcw_pkg::PH_IDLE;
      tick_q     <= 4'd0;
      clk_high_q <= 1'b0;
      bit_q      <= 3'd0;
      left_q     <= 4'd0;
      cmd_q      <= 8'd0;
      sout_q     <= 64'd0;
      sin_q      <= 64'd0;
      is_write_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q    <= phase_d;
        tick_q     <= tick_d;
        clk_high_q <= clk_high_d;
        bit_q      <= bit_d;
        left_q     <= left_d;
        cmd_q      <= cmd_d;
        sout_q     <= sout_d;
        sin_q      <= sin_d;
        is_write_q <= is_write_d;
      end
      out_valid_q <= accept || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sck_q  <= sck_c;
      sdo_q  <= sdo_c;
      drv_q  <= drv_c;
      cs_q   <= cs_c;
      done_q <= done_c;
      busy_q <= busy_c;
      rdp_q  <= sin_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sck_o          = sck_q;
  assign sio_out_o      = sdo_q;
  assign sio_drive_o    = drv_q;
  assign chip_select_o  = cs_q;
  assign read_payload_o = rdp_q;
  assign done_res_o     = done_q;
  assign busy_res_o     = busy_q;

  a_done_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !busy_q && !cs_q && !drv_q)
    else $error("Done beat shows an active bus.");

  a_released_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !drv_q |-> !sdo_q)
    else $error("Data level set while the pin is released.");

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q == rtcw_pkg::PH_END |=> phase_q == rtcw_pkg::PH_IDLE)
    else $error("End phase did not return to idle.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("Input stalled with an empty output register.");

endmodule

/* dv/rtcw_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the pin levels of the three-wire clock master and compares each result beat.
module rtcw_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        start_req_i,
  input  logic        write_mode_i,
  input  logic [2:0]  reg_index_i,
  input  logic [3:0]  byte_count_i,
  input  logic [63:0] write_payload_i,
  input  logic        sio_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        sck_i,
  input  logic        sio_out_i,
  input  logic        sio_drive_i,
  input  logic        chip_select_i,
  input  logic [63:0] read_payload_i,
  input  logic        done_res_i,
  input  logic        busy_res_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        sck;
    logic        sdo;
    logic        drv;
    logic        cs;
    logic [63:0] rx;
    logic        done;
    logic        busy;
  } pins_t;

  pins_t            pins_q[$];
  rtcw_pkg::phase_e seq_phase;
  logic [3:0]       tick_cnt;
  logic [2:0]       bit_idx;
  logic [3:0]       bytes_left;
  logic [63:0]      data_shift;
  logic [7:0]       cmd_shift;
  logic [63:0]      rx_shift;
  logic             xfer_write;
  logic             sck_high;
  logic [3:0]       wr_low_ticks;
  logic [3:0]       rd_low_ticks;
  logic [3:0]       hi_ticks;
  int               mismatch_cnt;

  assign fail_count_o = mismatch_cnt;

  function automatic logic [3:0] at_least_one(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  // Moves the serial clock on by one tick and tells whether the bit has ended.
  function automatic logic clock_tick(input logic [3:0] low_ticks);
    logic [4:0] nxt;
    nxt = {1'b0, tick_cnt} + 5'd1;
    if (!sck_high) begin
      if (nxt >= {1'b0, at_least_one(low_ticks)}) begin
        tick_cnt = '0;
        sck_high = 1'b1;
      end else begin
        tick_cnt = nxt[3:0];
      end
      return 1'b0;
    end
    if (nxt >= {1'b0, at_least_one(hi_ticks)}) begin
      tick_cnt = '0;
      sck_high = 1'b0;
      return 1'b1;
    end
    tick_cnt = nxt[3:0];
    return 1'b0;
  endfunction

  function automatic void close_bit(input logic data_byte);
    if (bit_idx != rtcw_pkg::LAST_BIT) begin
      bit_idx = bit_idx + 3'd1;
    end else begin
      bit_idx = '0;
      if (data_byte && bytes_left != 4'd0) bytes_left = bytes_left - 4'd1;
      if (bytes_left == 4'd0) begin
        seq_phase = rtcw_pkg::PH_END;
      end else if (!data_byte) begin
        seq_phase = xfer_write ? rtcw_pkg::PH_WR : rtcw_pkg::PH_RD;
      end
    end
  endfunction

  function automatic pins_t next_pins(input logic start, input logic wm,
                                      input logic [2:0] idx, input logic [3:0] cnt_raw,
                                      input logic [63:0] pay, input logic sio);
    pins_t      p;
    logic [3:0] cnt;
    p = '0;
    p.sck = 1'b1;
    cnt = (cnt_raw > rtcw_pkg::MAX_BYTES) ? rtcw_pkg::MAX_BYTES : cnt_raw;
    case (seq_phase)
      rtcw_pkg::PH_IDLE: begin
        if (start) begin
          xfer_write = wm;
          bytes_left = cnt;
          cmd_shift = {4'b0, idx, 1'b0} | (wm ? rtcw_pkg::CMD_WRITE : rtcw_pkg::CMD_READ);
          data_shift = wm ? pay : 64'd1;
          rx_shift = '0;
          tick_cnt = '0;
          bit_idx = '0;
          sck_high = 1'b0;
          p.drv = 1'b1;
          p.busy = 1'b1;
          seq_phase = rtcw_pkg::PH_RAISE;
        end
      end
      rtcw_pkg::PH_RAISE: begin
        p.cs = 1'b1;
        p.drv = 1'b1;
        p.busy = 1'b1;
        seq_phase = rtcw_pkg::PH_CMD;
      end
      rtcw_pkg::PH_CMD: begin
        p.cs = 1'b1;
        p.drv = 1'b1;
        p.busy = 1'b1;
        p.sck = sck_high;
        p.sdo = cmd_shift[7];
        if (clock_tick(wr_low_ticks)) begin
          cmd_shift = cmd_shift << 1;
          close_bit(1'b0);
        end
      end
      rtcw_pkg::PH_WR: begin
        p.cs = 1'b1;
        p.drv = 1'b1;
        p.busy = 1'b1;
        p.sck = sck_high;
        p.sdo = data_shift[0];
        if (clock_tick(wr_low_ticks)) begin
          data_shift = data_shift >> 1;
          close_bit(1'b1);
        end
      end
      rtcw_pkg::PH_RD: begin
        p.cs = 1'b1;
        p.busy = 1'b1;
        p.sck = sck_high;
        if (clock_tick(rd_low_ticks)) begin
          if (sio) rx_shift = rx_shift | data_shift;
          data_shift = data_shift << 1;
          close_bit(1'b1);
        end
      end
      rtcw_pkg::PH_END: begin
        p.done = 1'b1;
        seq_phase = rtcw_pkg::PH_IDLE;
      end
      default: seq_phase = rtcw_pkg::PH_IDLE;
    endcase
    p.rx = rx_shift;
    return p;
  endfunction

  task automatic flag_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp);
    if (got !== exp) flag_error($sformatf("%s: got %0h, expected %0h", name, got, exp));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pins_t want;
    if (!rst_ni) begin
      pins_q.delete();
      seq_phase = rtcw_pkg::PH_IDLE;
      tick_cnt = '0;
      bit_idx = '0;
      bytes_left = '0;
      data_shift = '0;
      cmd_shift = '0;
      rx_shift = '0;
      xfer_write = 1'b0;
      sck_high = 1'b0;
      wr_low_ticks = rtcw_pkg::WRITE_LOW_RESET;
      rd_low_ticks = rtcw_pkg::READ_LOW_RESET;
      hi_ticks = rtcw_pkg::HIGH_RESET;
      mismatch_cnt = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (rtcw_pkg::cfg_idx_e'(cfg_idx_i))
          rtcw_pkg::CFG_WRITE_LOW: wr_low_ticks = cfg_wdata_i;
          rtcw_pkg::CFG_READ_LOW:  rd_low_ticks = cfg_wdata_i;
          rtcw_pkg::CFG_HIGH:      hi_ticks = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pins_q.size() == 0) begin
          flag_error("result beat with no expectation waiting");
        end else begin
          want = pins_q.pop_front();
          check_field("sck", sck_i, want.sck);
          check_field("sio_out", sio_out_i, want.sdo);
          check_field("sio_drive", sio_drive_i, want.drv);
          check_field("chip_select", chip_select_i, want.cs);
          check_field("read_payload", read_payload_i, want.rx);
          check_field("done_res", done_res_i, want.done);
          check_field("busy_res", busy_res_i, want.busy);
        end
      end
      if (in_valid_i && in_ready_i) begin
        pins_q.push_back(next_pins(start_req_i, write_mode_i, reg_index_i, byte_count_i,
                                   write_payload_i, sio_in_i));
      end
      pending_o <= pins_q.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the three-wire clock master: clock, reset, stimulus and verdict.
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {
    SIO_LOW,
    SIO_HIGH,
    SIO_RAND
  } sio_pat_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               start_req = 1'b0;
  logic               write_mode = 1'b0;
  logic [2:0]         reg_index = '0;
  logic [3:0]         byte_count = '0;
  logic [63:0]        write_payload = '0;
  logic               sio_in = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               sck;
  logic               sio_out;
  logic               sio_drive;
  logic               chip_select;
  logic [63:0]        read_payload;
  logic               done_res;
  logic               busy_res;
  logic               cfg_we = 1'b0;
  rtcw_pkg::cfg_idx_e cfg_idx = rtcw_pkg::CFG_WRITE_LOW;
  logic [3:0]         cfg_wdata = '0;

  int   fail_count;
  int   pending;
  int   done_cnt = 0;
  int   cycle_cnt = 0;
  int   burst_left = 0;
  logic hold_req = 1'b0;
  logic held = 1'b0;

  rtc_three_wire_master_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .start_req_i    (start_req),
    .write_mode_i   (write_mode),
    .reg_index_i    (reg_index),
    .byte_count_i   (byte_count),
    .write_payload_i(write_payload),
    .sio_in_i       (sio_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sck_o          (sck),
    .sio_out_o      (sio_out),
    .sio_drive_o    (sio_drive),
    .chip_select_o  (chip_select),
    .read_payload_o (read_payload),
    .done_res_o     (done_res),
    .busy_res_o     (busy_res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  rtcw_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .start_req_i    (start_req),
    .write_mode_i   (write_mode),
    .reg_index_i    (reg_index),
    .byte_count_i   (byte_count),
    .write_payload_i(write_payload),
    .sio_in_i       (sio_in),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .sck_i          (sck),
    .sio_out_i      (sio_out),
    .sio_drive_i    (sio_drive),
    .chip_select_i  (chip_select),
    .read_payload_i (read_payload),
    .done_res_i     (done_res),
    .busy_res_i     (busy_res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (out_valid && out_ready && done_res) done_cnt <= done_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL rtc_three_wire_master_core");
      $finish;
    end
  end

  // The receiver stalls on a changing pattern, and once holds off long enough to back up the input.
  initial begin : receiver
    logic [7:0] stall_pat;
    int         pat_left;
    int         pat_pos;
    stall_pat = 8'hFF;
    pat_left = 0;
    pat_pos = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (pat_left == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = 8'hFF;
            1: stall_pat = 8'($urandom | $urandom);
            2: stall_pat = 8'($urandom);
            default: stall_pat = 8'($urandom & $urandom);
          endcase
          stall_pat[0] = 1'b1;
          pat_left = $urandom_range(16, 96);
        end
        out_ready <= stall_pat[pat_pos % 8];
        pat_pos++;
        pat_left--;
      end
    end
  end

  function automatic logic sio_bit(input sio_pat_e pat);
    case (pat)
      SIO_LOW:  return 1'b0;
      SIO_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Offers one tick beat and returns at the falling edge after it is taken.
  task automatic send_tick(input logic st, input logic wm, input logic [2:0] idx,
                           input logic [3:0] cnt, input logic [63:0] pay, input logic sio);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    start_req <= st;
    write_mode <= wm;
    reg_index <= idx;
    byte_count <= cnt;
    write_payload <= pay;
    sio_in <= sio;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic write_ticks(input logic [3:0] wl, input logic [3:0] rl, input logic [3:0] hi);
    cfg_we <= 1'b1;
    cfg_idx <= rtcw_pkg::CFG_WRITE_LOW;
    cfg_wdata <= wl;
    @(negedge clk);
    cfg_idx <= rtcw_pkg::CFG_READ_LOW;
    cfg_wdata <= rl;
    @(negedge clk);
    cfg_idx <= rtcw_pkg::CFG_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // One transaction: a start beat, then filler ticks until its done pulse has come out.
  // Fillers below the hammer count, and the one at end_hit, carry a start request too.
  task automatic run_xfer(input logic wm, input logic [2:0] idx, input logic [3:0] cnt,
                          input logic [63:0] pay, input sio_pat_e pat, input int hammer,
                          input int end_hit);
    int target;
    int k;
    target = done_cnt + 1;
    send_tick(1'b1, wm, idx, cnt, pay, sio_bit(pat));
    k = 0;
    while (done_cnt < target) begin
      send_tick(k < hammer || k == end_hit, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                4'($urandom_range(0, 15)), {$urandom, $urandom}, sio_bit(pat));
      k++;
    end
  endtask

  task automatic run_random(input int n, input logic slow, input int hold_at);
    logic [3:0] cnt;
    for (int i = 0; i < n; i++) begin
      if (slow) begin
        cnt = 4'($urandom_range(0, 1));
      end else if ($urandom_range(0, 4) == 0) begin
        cnt = 4'($urandom_range(0, 15));
      end else begin
        cnt = 4'($urandom_range(0, 3));
      end
      if (i == hold_at) hold_req <= 1'b1;
      send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                cnt, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset tick settings; a start request also lands on the end tick.
    run_xfer(1'b0, 3'd0, 4'd0, 64'd0, SIO_LOW, 0,
             1 + 8 * (int'(rtcw_pkg::WRITE_LOW_RESET) + int'(rtcw_pkg::HIGH_RESET)));
    settle();
    write_ticks(4'd1, 4'd1, 4'd1);
    run_xfer(1'b1, 3'd7, 4'd8, '1, SIO_RAND, 0, -1);
    run_xfer(1'b0, 3'd6, 4'd15, 64'd0, SIO_RAND, 12, -1);
    run_xfer(1'b0, 3'd3, 4'd1, 64'd0, SIO_HIGH, 0, -1);
    run_xfer(1'b1, 3'd5, 4'd0, {$urandom, $urandom}, SIO_RAND, 0, 17);
    run_xfer(1'b1, 3'd2, 4'd3, 64'hA5A5_5A5A_0FF0_F00F, SIO_RAND, 0, -1);

    run_random(60, 1'b0, 30);
    settle();
    write_ticks(4'd0, 4'd0, 4'd0);
    run_random(30, 1'b0, -1);
    settle();
    write_ticks(4'd15, 4'd15, 4'd15);
    run_random(30, 1'b1, -1);
    settle();
    write_ticks(4'd2, 4'd4, 4'd3);
    run_random(30, 1'b0, -1);
    settle();
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS rtc_three_wire_master_core");
    end else begin
      $display("FAIL rtc_three_wire_master_core");
    end
    $finish;
  end

endmodule
